FILE: hw/rtl/tte_pkg.sv
package tte_pkg;

    // request function codes
    typedef logic [1:0] t_func;
    localparam t_func F_LOAD_INDEX = 2'd0;
    localparam t_func F_LOAD_BYTE  = 2'd1;
    localparam t_func F_NAME_LEN   = 2'd2;
    localparam t_func F_CODE       = 2'd3;

    // result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind K_CHAR = 2'd0;
    localparam t_kind K_TYPE = 2'd1;
    localparam t_kind K_END  = 2'd2;
    localparam t_kind K_ERR  = 2'd3;

    // error codes carried in the character field
    localparam logic [7:0] ERR_OVERLONG = 8'd0;
    localparam logic [7:0] ERR_STRAY    = 8'd1;
    localparam logic [7:0] END_CHAR     = 8'd0;

    localparam int INDEX_DEPTH = 256;
    localparam int INDEX_AW    = 8;
    localparam int START_W     = 12;
    localparam int SLOT_W      = 12;
    localparam int VALUE_W     = 12;
    localparam int CHAR_W      = 8;

    typedef struct packed {
        logic       take;        // request accepted this cycle
        logic       ptr_load;    // load pointer from index read data
        logic       ptr_reduce;  // subtract table size from pointer
        logic       scan_begin;  // latch token start, first byte read
        logic       scan_next;   // next byte of the terminator search
        logic       scan_hit;    // terminator found, rewind for output
        logic       prime;       // first byte read of the output pass
        logic       emit;        // send one token character
        logic       code_done;   // count off one code byte
        logic       name_close;  // clear the open name
        logic       res_load;    // send a single closing result
        t_kind      res_kind;
        logic [7:0] res_char;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  len_zero;     // length byte of zero
        logic  codes_zero;   // no name open
        logic  last_code;    // one code byte left
        logic  ptr_above;    // pointer at or beyond table size
        logic  char_zero;    // read byte is a terminator
        logic  cnt_at_max;   // byte count at token bound
        logic  cnt_zero;
        logic  emit_final;   // last character of the token
        logic  out_free;     // output register can take a result
    } t_sts;

endpackage

FILE: hw/rtl/token_table_name_expander_top.sv
// Loads and length bytes are handled in the idle state; a zero length byte also sends the closing result.
// A code byte passes an index read, pointer reduction steps while the start is at or beyond TABLE_BYTES,
// a terminator scan and an output pass, each bound by the single read port of the token byte
// memory; one character leaves per cycle in the output pass while the output register is free.
// Results pass through one output register. Synchronous active-low reset clears the controller,
// the open-name state and the output valid; the token memories are not cleared.
module token_table_name_expander_top import tte_pkg::*; #(
    parameter int TABLE_BYTES     = 4096,
    parameter int MAX_TOKEN_CHARS = 62
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [CHAR_W-1:0]  o_char_value,
    output logic               o_last
);

    t_cmd cmd;
    t_sts sts;

    tte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tte_dp #(
        .TABLE_BYTES     (TABLE_BYTES),
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_func       (i_func),
        .i_slot       (i_slot),
        .i_value      (i_value),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_char_value (o_char_value),
        .o_last       (o_last),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

FILE: hw/rtl/tte_ram.sv
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tte_dp.sv
module tte_dp import tte_pkg::*; #(
    parameter int TABLE_BYTES     = 4096,
    parameter int MAX_TOKEN_CHARS = 62
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_func              i_func,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_ready,
    output logic               o_valid,
    output t_kind              o_kind,
    output logic [CHAR_W-1:0]  o_char_value,
    output logic               o_last,
    input  t_cmd               i_cmd,
    output t_sts               o_sts
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam int PW = (AW + 1 > START_W) ? AW + 1 : START_W;
    localparam int CW = $clog2(MAX_TOKEN_CHARS + 1);

    logic [PW-1:0]      r_addr, n_addr, addr_inc;
    logic [AW-1:0]      r_start;
    logic [CW-1:0]      r_cnt, r_len;
    logic [7:0]         r_codes_left;
    logic               r_type_pending;
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic [START_W-1:0] idx_rdata;
    logic [CHAR_W-1:0]  chr_rdata;
    logic               idx_we, chr_we, chr_re;
    logic               out_free;

    assign idx_we = i_cmd.take && (i_func == F_LOAD_INDEX)
                    && (i_slot < SLOT_W'(INDEX_DEPTH));
    assign chr_we = i_cmd.take && (i_func == F_LOAD_BYTE)
                    && (32'(i_slot) < TABLE_BYTES);
    assign chr_re = i_cmd.scan_begin || i_cmd.scan_next || i_cmd.prime || i_cmd.emit;

    tte_ram #(.WIDTH(START_W), .DEPTH(INDEX_DEPTH)) u_index (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (i_slot[INDEX_AW-1:0]),
        .i_wdata (i_value),
        .i_re    (i_cmd.take),
        .i_raddr (i_value[INDEX_AW-1:0]),
        .o_rdata (idx_rdata)
    );

    tte_ram #(.WIDTH(CHAR_W), .DEPTH(TABLE_BYTES)) u_chars (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata (i_value[CHAR_W-1:0]),
        .i_re    (chr_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (chr_rdata)
    );

    // wrap at the table end
    assign addr_inc = (r_addr == PW'(TABLE_BYTES - 1)) ? '0 : r_addr + PW'(1);

    always_comb begin
        n_addr = r_addr;
        if (i_cmd.ptr_load) begin
            n_addr = PW'(idx_rdata);
        end else if (i_cmd.ptr_reduce) begin
            n_addr = r_addr - PW'(TABLE_BYTES);
        end else if (i_cmd.scan_hit) begin
            n_addr = PW'(r_start);
        end else if (chr_re) begin
            n_addr = addr_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (i_cmd.scan_begin) begin
            r_start <= r_addr[AW-1:0];
        end
        if (i_cmd.scan_begin || i_cmd.prime) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_next || i_cmd.emit) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.scan_hit) begin
            r_len <= r_cnt;
        end
    end

    // name state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes_left   <= '0;
            r_type_pending <= 1'b0;
        end else begin
            if (i_cmd.take && (i_func == F_NAME_LEN)) begin
                r_codes_left   <= i_value[7:0];
                r_type_pending <= (i_value[7:0] != 8'd0);
            end else if (i_cmd.name_close) begin
                r_codes_left   <= '0;
                r_type_pending <= 1'b0;
            end else if (i_cmd.code_done) begin
                r_codes_left <= r_codes_left - 8'd1;
                if (r_codes_left == 8'd1) begin
                    r_type_pending <= 1'b0;
                end
            end else if (i_cmd.emit) begin
                r_type_pending <= 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= r_type_pending ? K_TYPE : K_CHAR;
            r_out_char <= chr_rdata;
            r_out_last <= o_sts.emit_final && (r_codes_left != 8'd1);
        end else if (i_cmd.res_load) begin
            r_out_kind <= i_cmd.res_kind;
            r_out_char <= i_cmd.res_char;
            r_out_last <= 1'b1;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_char_value = r_out_char;
    assign o_last       = r_out_last;

    always_comb begin
        o_sts.func       = i_func;
        o_sts.len_zero   = (i_value[7:0] == 8'd0);
        o_sts.codes_zero = (r_codes_left == 8'd0);
        o_sts.last_code  = (r_codes_left == 8'd1);
        o_sts.ptr_above  = (r_addr >= PW'(TABLE_BYTES));
        o_sts.char_zero  = (chr_rdata == '0);
        o_sts.cnt_at_max = (r_cnt == CW'(MAX_TOKEN_CHARS));
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.emit_final = ((r_cnt + CW'(1)) == r_len);
        o_sts.out_free   = out_free;
    end

endmodule

FILE: hw/rtl/tte_ctrl.sv
module tte_ctrl import tte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IDX   = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_PRIME = 4'd4;
    localparam logic [3:0] S_EMIT  = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_ERR0  = 4'd8;
    localparam logic [3:0] S_ERR1  = 4'd9;

    logic [3:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_sts.func)
                        F_NAME_LEN: begin
                            if (i_sts.len_zero) begin
                                n_state = S_END;
                            end
                        end
                        F_CODE: begin
                            n_state = i_sts.codes_zero ? S_ERR1 : S_IDX;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_IDX: begin
                o_cmd.ptr_load = 1'b1;
                n_state        = S_RED;
            end
            S_RED: begin
                if (i_sts.ptr_above) begin
                    o_cmd.ptr_reduce = 1'b1;
                end else begin
                    o_cmd.scan_begin = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.char_zero) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = i_sts.cnt_zero ? S_FIN : S_PRIME;
                end else if (i_sts.cnt_at_max) begin
                    // no terminator within bound: drop the name
                    o_cmd.name_close = 1'b1;
                    n_state          = S_ERR0;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_final) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                o_cmd.code_done = 1'b1;
                n_state         = i_sts.last_code ? S_END : S_IDLE;
            end
            S_END, S_ERR0, S_ERR1: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
                unique case (r_state)
                    S_END: begin
                        o_cmd.res_kind = K_END;
                        o_cmd.res_char = END_CHAR;
                    end
                    S_ERR0: begin
                        o_cmd.res_kind = K_ERR;
                        o_cmd.res_char = ERR_OVERLONG;
                    end
                    default: begin
                        o_cmd.res_kind = K_ERR;
                        o_cmd.res_char = ERR_STRAY;
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: bench/token_table_name_expander_checker.sv
module token_table_name_expander_checker import tte_pkg::*; #(
    parameter int TABLE_BYTES     = 4096,
    parameter int MAX_TOKEN_CHARS = 62
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [1:0]         i_func,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [1:0]         i_kind,
    input  logic [CHAR_W-1:0]  i_char_value,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_value;
        logic              last;
    } t_name_result;

    logic [START_W-1:0] token_start_mem [INDEX_DEPTH];
    logic [CHAR_W-1:0]  token_byte_mem  [TABLE_BYTES];
    logic [7:0]         codes_open;
    logic               type_due;
    t_name_result       expected_chars [$];
    int                 fail_count   = 0;
    int                 result_count = 0;

    task automatic push_result(t_kind kind, logic [CHAR_W-1:0] char_value);
        expected_chars.push_back('{kind: kind, char_value: char_value, last: 1'b0});
    endtask

    // Work out every result one request causes and queue them in order.
    task automatic expand_request(logic [1:0] func, logic [SLOT_W-1:0] slot,
                                  logic [VALUE_W-1:0] value);
        int                before_count;
        int                base;
        int                tok_len;
        logic [CHAR_W-1:0] ch;
        before_count = expected_chars.size();
        case (func)
            F_LOAD_INDEX: begin
                if (slot < INDEX_DEPTH)
                    token_start_mem[slot[INDEX_AW-1:0]] = value[START_W-1:0];
            end
            F_LOAD_BYTE: begin
                if (slot < TABLE_BYTES)
                    token_byte_mem[slot] = value[CHAR_W-1:0];
            end
            F_NAME_LEN: begin
                codes_open = value[7:0];
                type_due   = (value[7:0] != 8'd0);
                if (value[7:0] == 8'd0)
                    push_result(K_END, END_CHAR);
            end
            F_CODE: begin
                if (codes_open == 8'd0) begin
                    push_result(K_ERR, ERR_STRAY);
                end else begin
                    base    = int'(token_start_mem[value[INDEX_AW-1:0]]);
                    tok_len = -1;
                    for (int i = 0; i <= MAX_TOKEN_CHARS; i++)
                        if (tok_len < 0 && token_byte_mem[(base + i) % TABLE_BYTES] == 8'd0)
                            tok_len = i;
                    if (tok_len < 0) begin
                        // no terminator within bound: close the name, error only
                        codes_open = 8'd0;
                        type_due   = 1'b0;
                        push_result(K_ERR, ERR_OVERLONG);
                    end else begin
                        for (int i = 0; i < tok_len; i++) begin
                            ch = token_byte_mem[(base + i) % TABLE_BYTES];
                            push_result(type_due ? K_TYPE : K_CHAR, ch);
                            type_due = 1'b0;
                        end
                        codes_open = codes_open - 8'd1;
                        if (codes_open == 8'd0) begin
                            type_due = 1'b0;
                            push_result(K_END, END_CHAR);
                        end
                    end
                end
            end
        endcase
        if (expected_chars.size() > before_count)
            expected_chars[expected_chars.size() - 1].last = 1'b1;
    endtask

    task automatic compare_result();
        t_name_result want;
        result_count++;
        if (expected_chars.size() == 0) begin
            $error("result with nothing expected: kind %0d char_value %02h last %0d",
                   i_kind, i_char_value, i_last);
            fail_count++;
        end else begin
            want = expected_chars.pop_front();
            if (i_kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, i_kind);
                fail_count++;
            end
            if (i_char_value !== want.char_value) begin
                $error("char_value: expected %02h, actual %02h", want.char_value, i_char_value);
                fail_count++;
            end
            if (i_last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, i_last);
                fail_count++;
            end
        end
    endtask

    // Results first: a result leaving at this edge never stems from a request taken at it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            codes_open = 8'd0;
            type_due   = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                compare_result();
            if (i_req_valid && i_req_ready)
                expand_request(i_func, i_slot, i_value);
        end
        o_pending    = expected_chars.size();
        o_fail_count = fail_count;
        o_results    = result_count;
    end

endmodule

FILE: bench/token_table_name_expander_top_test.sv
module token_table_name_expander_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tte_pkg::*;

    localparam int TABLE_BYTES     = 4096;
    localparam int MAX_TOKEN_CHARS = 62;
    localparam int RANDOM_REQUESTS = 140;
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int WORD_BASE       = 200;
    localparam int OVERLONG_START  = 1000;

    // index slots of the directed dictionary; slots 0 to 3 hold the short words
    localparam int SLOT_MOV      = 0;
    localparam int SLOT_US       = 1;
    localparam int SLOT_INIT     = 2;
    localparam int SLOT_X        = 3;
    localparam int SLOT_PAIR     = 17;
    localparam int SLOT_EMPTY    = 64;
    localparam int SLOT_LONGEST  = 127;
    localparam int SLOT_TRIO     = 128;
    localparam int SLOT_OVERLONG = 200;
    localparam int SLOT_WRAP     = 255;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [SLOT_W-1:0]  i_slot;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_kind;
    logic [CHAR_W-1:0]  o_char_value;
    logic               o_last;

    int fail_count;
    int pending;
    int results;

    // stimulus-side view of what has been loaded, to keep every lookup on written entries
    logic [START_W-1:0] start_of    [INDEX_DEPTH];
    bit                 idx_loaded  [INDEX_DEPTH];
    int                 loaded_slots [$];
    logic [CHAR_W-1:0]  byte_of     [TABLE_BYTES];
    bit                 byte_loaded [TABLE_BYTES];
    int                 loaded_bytes [$];
    int                 open_codes    = 0;
    int                 burst_left    = 0;
    int                 hold_asks     = 0;
    int                 requests_sent = 0;
    int                 names_opened  = 0;
    int                 strays        = 0;
    int                 overlongs     = 0;
    int                 idle_cycles   = 0;

    always #1 i_clk = ~i_clk;

    token_table_name_expander_top #(
        .TABLE_BYTES     (TABLE_BYTES),
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) i_dut (.*);

    token_table_name_expander_checker #(
        .TABLE_BYTES     (TABLE_BYTES),
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_func       (i_func),
        .i_slot       (i_slot),
        .i_value      (i_value),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_kind       (o_kind),
        .i_char_value (o_char_value),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    // Enter and leave at a falling edge; valid stays up across a burst.
    task automatic send_request(logic [1:0] func, logic [SLOT_W-1:0] slot,
                                logic [VALUE_W-1:0] value);
        int gap;
        i_valid <= 1'b1;
        i_func  <= func;
        i_slot  <= slot;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic load_byte(int pos, logic [CHAR_W-1:0] char_value);
        send_request(F_LOAD_BYTE, SLOT_W'(pos), {4'($urandom), char_value});
        byte_of[pos] = char_value;
        if (!byte_loaded[pos]) begin
            byte_loaded[pos] = 1'b1;
            loaded_bytes.push_back(pos);
        end
    endtask

    task automatic load_index(int slot, int start);
        send_request(F_LOAD_INDEX, SLOT_W'(slot), VALUE_W'(start));
        start_of[slot] = START_W'(start);
        if (!idx_loaded[slot]) begin
            idx_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
    endtask

    task automatic open_name(int len);
        send_request(F_NAME_LEN, SLOT_W'($urandom), {4'($urandom), 8'(len)});
        open_codes = len;
        names_opened++;
    endtask

    task automatic send_code(int slot);
        send_request(F_CODE, SLOT_W'($urandom), {4'($urandom), 8'(slot)});
        if (open_codes == 0) begin
            strays++;
        end else if (start_of[slot] == START_W'(OVERLONG_START)) begin
            open_codes = 0;
            overlongs++;
        end else begin
            open_codes--;
        end
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic int pick_code();
        int slot;
        slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
        // overlong tokens end the name, so draw again most of the time
        if (start_of[slot] == START_W'(OVERLONG_START) && $urandom_range(0, 3) != 0)
            slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
        return slot;
    endfunction

    // receiver: phases of always ready, even stalls and heavy stalls, plus requested hold-offs
    initial begin
        int hold_served;
        int phase_left;
        int mode;
        hold_served = 0;
        phase_left  = 0;
        mode        = 0;
        i_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks > hold_served) begin
                hold_served++;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 80);
            end
            phase_left--;
            case (mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding", IDLE_LIMIT, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        string       words [4] = '{"mov", "_", "init", "x"};
        logic [7:0]  wrap_bytes [6] = '{8'h7F, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h00};
        int          pos;
        int          len;
        int          len_pick;
        int          n_codes;
        int          choice;
        int          random_sent;
        bit          paused;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_func  <= F_LOAD_INDEX;
        i_slot  <= '0;
        i_value <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // dictionary: short words, a long run with a single terminator, a token across the wrap
        pos = WORD_BASE;
        foreach (words[w]) begin
            load_index(w, pos);
            for (int k = 0; k < words[w].len(); k++) begin
                load_byte(pos, words[w][k]);
                pos++;
            end
            load_byte(pos, 8'h00);
            pos++;
        end
        for (int k = 0; k <= MAX_TOKEN_CHARS; k++)
            load_byte(OVERLONG_START + k, 8'(1 + (k * 37) % 255));
        load_byte(OVERLONG_START + MAX_TOKEN_CHARS + 1, 8'h00);
        foreach (wrap_bytes[k])
            load_byte((TABLE_BYTES - 3 + k) % TABLE_BYTES, wrap_bytes[k]);
        load_index(SLOT_OVERLONG, OVERLONG_START);
        load_index(SLOT_LONGEST, OVERLONG_START + 1);
        load_index(SLOT_TRIO, OVERLONG_START + MAX_TOKEN_CHARS - 2);
        load_index(SLOT_EMPTY, OVERLONG_START + MAX_TOKEN_CHARS + 1);
        load_index(SLOT_WRAP, TABLE_BYTES - 2);
        load_index(SLOT_PAIR, 0);
        // index slot out of range: dropped by the block
        send_request(F_LOAD_INDEX, SLOT_W'(12'hFFF), VALUE_W'($urandom));

        // directed names
        send_code(SLOT_WRAP);
        open_name(0);
        open_name(2);
        send_code(SLOT_MOV);
        send_code(SLOT_US);
        open_name(3);
        send_code(SLOT_EMPTY);
        send_code(SLOT_INIT);
        send_code(SLOT_X);
        open_name(2);
        send_code(SLOT_EMPTY);
        send_code(SLOT_EMPTY);
        open_name(1);
        send_code(SLOT_LONGEST);
        open_name(3);
        send_code(SLOT_TRIO);
        send_code(SLOT_OVERLONG);
        send_code(SLOT_MOV);
        open_name(2);
        send_code(SLOT_WRAP);
        send_code(SLOT_PAIR);
        open_name(5);
        send_code(SLOT_X);
        open_name(255);
        send_code(SLOT_TRIO);
        open_name(1);
        send_code(SLOT_INIT);
        drain_results();

        random_sent = 0;
        paused      = 1'b0;
        while (random_sent < RANDOM_REQUESTS) begin
            // starve the output while requests keep coming, later let everything settle
            if (hold_asks == 0 && random_sent >= RANDOM_REQUESTS / 4)
                hold_asks <= 1;
            if (!paused && random_sent >= RANDOM_REQUESTS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            choice = $urandom_range(0, 99);
            if (choice < 65) begin
                len_pick = $urandom_range(0, 19);
                len = (len_pick == 0) ? 0 :
                      (len_pick < 15) ? $urandom_range(1, 4) :
                      (len_pick < 18) ? $urandom_range(5, 12) : $urandom_range(13, 255);
                n_codes = (len > 12) ? $urandom_range(1, 4) : len;
                // now and then leave the name open so the next length abandons it
                if (len > 0 && $urandom_range(0, 11) == 0)
                    n_codes = $urandom_range(0, len - 1);
                open_name(len);
                random_sent++;
                for (int k = 0; k < n_codes && open_codes > 0; k++) begin
                    send_code(pick_code());
                    random_sent++;
                end
            end else if (choice < 75) begin
                if (open_codes == 0)
                    send_code($urandom_range(0, 255));
                else
                    send_code(pick_code());
                random_sent++;
            end else if (choice < 87) begin
                // rewrite a byte, keeping terminators where they are
                pos = loaded_bytes[$urandom_range(0, loaded_bytes.size() - 1)];
                if (byte_of[pos] == 8'h00)
                    load_byte(pos, 8'h00);
                else
                    load_byte(pos, 8'($urandom_range(1, 255)));
                random_sent++;
            end else if (choice < 94) begin
                load_index($urandom_range(0, INDEX_DEPTH - 1),
                           start_of[loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]]);
                random_sent++;
            end else begin
                send_request(F_LOAD_INDEX, SLOT_W'($urandom_range(INDEX_DEPTH, 4095)),
                             VALUE_W'($urandom));
            end
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests sent, %0d names opened, %0d stray codes, %0d overlong tokens",
                 requests_sent, names_opened, strays, overlongs);
        $display("%0d results compared, %0d field mismatches", results, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
